>>> design/spq_pkg.sv
// Shared types and constants for the strict-priority task queue.
`default_nettype none
package spq_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_PRIO = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // Request kinds carried in s_tuser
    localparam logic MODE_PUSH     = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PRIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PEND = 2'd1;
    localparam int CFG_DATA_W = 7;

    // Field widths
    localparam int ID_W     = 32;
    localparam int PRIO_W   = 4;
    localparam int WEIGHT_W = 8;
    localparam int TASK_W   = ID_W + PRIO_W + WEIGHT_W;
    localparam int DATA_W   = 48;
    localparam int NPRIO_W  = 4;
    localparam int MAXP_W   = 7;

    localparam logic [NPRIO_W-1:0] NUM_PRIO_RST = 4'd8;
    localparam logic [MAXP_W-1:0]  MAX_PEND_RST = 7'd64;

    // Level table command
    typedef struct packed {
        logic push;
        logic pop;
    } tbl_cmd_t;

endpackage
`default_nettype wire

>>> design/strict_priority_task_queue_core.sv
// Strict-priority task queue: sequencer, configuration and result register.
// Push: accepted in ST_IDLE, checked and stored in ST_CHECK, result loaded in ST_DONE once m_* is free.
// Dispatch: the scan tests one level per cycle from the top down and stops at the first
//   level with a pending task, or at level 0 when nothing is pending.
// One request at a time; the next is taken while the previous result waits in m_*.
// aresetn (synchronous, active low) clears pointers, counts and the pending total and
//   restores num_priorities=8, max_pending=64; the task memory is not cleared.
`default_nettype none
module strict_priority_task_queue_core #(
    parameter int PRIO_LEVELS = 8,
    parameter int CAPACITY    = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input requests
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [spq_pkg::DATA_W-1:0]       s_tdata,  // task_id, task_prio, task_weight
    input  wire logic                             s_tuser,  // mode
    // Results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [spq_pkg::DATA_W-1:0]       m_tdata,  // out_id, out_prio, out_weight
    output logic      [2:0]                       m_tuser,  // status, dispatch_valid
    // Configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [spq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LVL_W   = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > spq_pkg::MAXP_W) ? CNT_W : spq_pkg::MAXP_W;
    localparam int ADDR_W  = LVL_W + PTR_W;
    localparam int DEPTH   = PRIO_LEVELS * (2 ** PTR_W);
    localparam int PCMP_W  = spq_pkg::PRIO_W + 1;

    spq_pkg::state_t state_reg, state_next;

    logic                            mode_reg;
    logic [spq_pkg::ID_W-1:0]        id_reg;
    logic [spq_pkg::PRIO_W-1:0]      prio_reg;
    logic [spq_pkg::WEIGHT_W-1:0]    weight_reg;
    logic [LVL_W-1:0]                lvl_reg, lvl_next;
    logic [1:0]                      status_reg, status_next;
    logic                            disp_reg, disp_next;

    logic [spq_pkg::NPRIO_W-1:0]     num_prio_reg;
    logic [spq_pkg::MAXP_W-1:0]      max_pend_reg;

    logic                            m_valid_reg;
    logic [spq_pkg::DATA_W-1:0]      m_data_reg;
    logic [2:0]                      m_user_reg;

    spq_pkg::tbl_cmd_t               cmd;
    logic                            cnt_nz;
    logic [PTR_W-1:0]                head_ptr;
    logic [PTR_W-1:0]                tail_ptr;
    logic [CNT_W-1:0]                total;
    logic [spq_pkg::TASK_W-1:0]      rd_data;

    logic                            s_fire;
    logic                            out_free;
    logic                            prio_bad;
    logic [CMP_W-1:0]                limit;
    logic                            full;
    logic                            push_ok;
    logic                            pop_go;

    assign s_tready  = (state_reg == spq_pkg::ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Push checks: priority range first, then shared limit
    assign prio_bad = (PCMP_W'(prio_reg) >= PCMP_W'(num_prio_reg))
                   || (PCMP_W'(prio_reg) >= PCMP_W'(PRIO_LEVELS));
    assign limit    = (CMP_W'(max_pend_reg) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                               : CMP_W'(max_pend_reg);
    assign full     = (CMP_W'(total) >= limit);
    assign push_ok  = (state_reg == spq_pkg::ST_CHECK) && !prio_bad && !full;
    assign pop_go   = (state_reg == spq_pkg::ST_SCAN) && cnt_nz;

    assign cmd.push = push_ok;
    assign cmd.pop  = pop_go;

    spq_level_table #(
        .PRIO_LEVELS (PRIO_LEVELS),
        .CAPACITY    (CAPACITY),
        .LVL_W       (LVL_W),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lvl      (lvl_reg),
        .cmd      (cmd),
        .cnt_nz   (cnt_nz),
        .head_ptr (head_ptr),
        .tail_ptr (tail_ptr),
        .total    (total)
    );

    spq_task_ram #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (push_ok),
        .wr_addr ({lvl_reg, tail_ptr}),
        .wr_data ({weight_reg, prio_reg, id_reg}),
        .rd_en   (pop_go),
        .rd_addr ({lvl_reg, head_ptr}),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        status_next = status_reg;
        disp_next   = disp_reg;
        case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == spq_pkg::MODE_PUSH) begin
                        lvl_next   = s_tdata[spq_pkg::ID_W +: LVL_W];
                        state_next = spq_pkg::ST_CHECK;
                    end else begin
                        lvl_next   = LVL_W'(PRIO_LEVELS - 1);
                        state_next = spq_pkg::ST_SCAN;
                    end
                end
            end
            spq_pkg::ST_CHECK: begin
                disp_next  = 1'b0;
                state_next = spq_pkg::ST_DONE;
                if (prio_bad) begin
                    status_next = spq_pkg::STAT_BAD_PRIO;
                end else if (full) begin
                    status_next = spq_pkg::STAT_FULL;
                end else begin
                    status_next = spq_pkg::STAT_OK;
                end
            end
            spq_pkg::ST_SCAN: begin
                if (cnt_nz) begin
                    status_next = spq_pkg::STAT_OK;
                    disp_next   = 1'b1;
                    state_next  = spq_pkg::ST_DONE;
                end else if (lvl_reg == '0) begin
                    status_next = spq_pkg::STAT_EMPTY;
                    disp_next   = 1'b0;
                    state_next  = spq_pkg::ST_DONE;
                end else begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            spq_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spq_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            num_prio_reg <= spq_pkg::NUM_PRIO_RST;
            max_pend_reg <= spq_pkg::MAX_PEND_RST;
        end else begin
            state_reg <= state_next;
            if (state_reg == spq_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == spq_pkg::REG_NUM_PRIO) begin
                    num_prio_reg <= cfg_data[spq_pkg::NPRIO_W-1:0];
                end else if (cfg_index == spq_pkg::REG_MAX_PEND) begin
                    max_pend_reg <= cfg_data[spq_pkg::MAXP_W-1:0];
                end
            end
        end
    end

    // Request capture and working payload
    always_ff @(posedge aclk) begin
        lvl_reg    <= lvl_next;
        status_reg <= status_next;
        disp_reg   <= disp_next;
        if (s_fire) begin
            mode_reg   <= s_tuser;
            id_reg     <= s_tdata[spq_pkg::ID_W-1:0];
            prio_reg   <= s_tdata[spq_pkg::ID_W +: spq_pkg::PRIO_W];
            weight_reg <= s_tdata[spq_pkg::ID_W + spq_pkg::PRIO_W +: spq_pkg::WEIGHT_W];
        end
    end

    // Load the result register; non-dispatch results carry zero task fields
    always_ff @(posedge aclk) begin
        if (state_reg == spq_pkg::ST_DONE && out_free) begin
            m_user_reg <= {disp_reg, status_reg};
            if (disp_reg && mode_reg == spq_pkg::MODE_DISPATCH) begin
                m_data_reg <= spq_pkg::DATA_W'(rd_data);
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A dispatched task always reports status ok
    a_disp_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == spq_pkg::STAT_OK)
        else $error("dispatch with non-ok status");

    // The pending total never exceeds the storage per level
    a_total_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(total) <= CMP_W'(CAPACITY))
        else $error("pending total above capacity");

    // A refused push leaves the pending total unchanged
    a_refuse_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == spq_pkg::ST_CHECK && (prio_bad || full) |=> $stable(total))
        else $error("refused push changed pending total");

    // A pop only happens on a level with queued tasks and lowers the total
    a_pop_total: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_go |=> total == $past(total) - CNT_W'(1))
        else $error("pop did not lower pending total");

endmodule
`default_nettype wire

>>> design/spq_task_ram.sv
// Task storage memory: one write port, one registered read port.
`default_nettype none
module spq_task_ram #(
    parameter int ADDR_W = 9,
    parameter int DEPTH  = 512
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [spq_pkg::TASK_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [spq_pkg::TASK_W-1:0] rd_data
);

    logic [spq_pkg::TASK_W-1:0] mem [DEPTH];
    logic [spq_pkg::TASK_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> design/spq_level_table.sv
// Per-level ring pointers and counts with one shared pointer-advance unit.
`default_nettype none
module spq_level_table #(
    parameter int PRIO_LEVELS = 8,
    parameter int CAPACITY    = 64,
    parameter int LVL_W       = 3,
    parameter int PTR_W       = 6,
    parameter int CNT_W       = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [LVL_W-1:0]  lvl,
    input  wire spq_pkg::tbl_cmd_t cmd,
    output logic                   cnt_nz,
    output logic      [PTR_W-1:0]  head_ptr,
    output logic      [PTR_W-1:0]  tail_ptr,
    output logic      [CNT_W-1:0]  total
);

    logic [PTR_W-1:0] head_reg  [PRIO_LEVELS];
    logic [PTR_W-1:0] tail_reg  [PRIO_LEVELS];
    logic [CNT_W-1:0] count_reg [PRIO_LEVELS];
    logic [CNT_W-1:0] total_reg;

    logic [PTR_W-1:0] adv_in;
    logic [PTR_W-1:0] adv_out;
    logic [CNT_W-1:0] cnt_cur;

    assign head_ptr = head_reg[lvl];
    assign tail_ptr = tail_reg[lvl];
    assign cnt_cur  = count_reg[lvl];
    assign cnt_nz   = (cnt_cur != '0);
    assign total    = total_reg;

    // Shared ring advance: tail on push, head on pop
    assign adv_in  = cmd.push ? tail_ptr : head_ptr;
    assign adv_out = (adv_in == PTR_W'(CAPACITY - 1)) ? '0 : adv_in + PTR_W'(1);

    // Update the selected level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PRIO_LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg <= '0;
        end else if (cmd.push) begin
            tail_reg[lvl]  <= adv_out;
            count_reg[lvl] <= cnt_cur + CNT_W'(1);
            total_reg      <= total_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            head_reg[lvl]  <= adv_out;
            count_reg[lvl] <= cnt_cur - CNT_W'(1);
            if (total_reg != '0) begin
                total_reg <= total_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> sim/tb_strict_priority_task_queue_core.sv
// Self-checking testbench for the strict-priority task queue core.
`default_nettype none
module tb_strict_priority_task_queue_core;

    localparam int LEVELS      = 8;
    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 10;

    // Indexes past the register list, written to check that they are ignored
    localparam logic [spq_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [spq_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Task as it sits on the bus: id in the low bits, then priority, then weight
    typedef struct packed {
        logic [spq_pkg::WEIGHT_W-1:0] weight;
        logic [spq_pkg::PRIO_W-1:0]   prio;
        logic [spq_pkg::ID_W-1:0]     id;
    } job_t;

    typedef struct {
        logic [1:0] status;
        logic       handed;
        job_t       job;
    } outcome_t;

    // Priority queue predictor plus the list of outcomes still owed by the block
    class task_queue_scoreboard;
        job_t        slots [LEVELS][DEPTH];
        int unsigned head [LEVELS];
        int unsigned tail [LEVELS];
        int unsigned count [LEVELS];
        int unsigned total;
        int unsigned levels_cfg;
        int unsigned limit_cfg;
        outcome_t    outcomes_due[$];
        int unsigned failures;

        function new();
            for (int l = 0; l < LEVELS; l++) begin
                head[l]  = 0;
                tail[l]  = 0;
                count[l] = 0;
            end
            total      = 0;
            levels_cfg = spq_pkg::NUM_PRIO_RST;
            limit_cfg  = spq_pkg::MAX_PEND_RST;
            failures   = 0;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function void write_register(logic [spq_pkg::CFG_IDX_W-1:0] idx,
                                     logic [spq_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spq_pkg::REG_NUM_PRIO: levels_cfg = data[spq_pkg::NPRIO_W-1:0];
                spq_pkg::REG_MAX_PEND: limit_cfg  = data[spq_pkg::MAXP_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the outcome of one accepted request and queue it
        function void note_request(logic mode, job_t req);
            outcome_t    res;
            int unsigned lvl_cap;
            int unsigned pend_cap;
            int          l;
            bit          served;
            res.status = spq_pkg::STAT_OK;
            res.handed = 1'b0;
            res.job    = '0;
            served     = 1'b0;
            if (mode == spq_pkg::MODE_PUSH) begin
                lvl_cap  = (levels_cfg > LEVELS) ? LEVELS : levels_cfg;
                pend_cap = (limit_cfg > DEPTH) ? DEPTH : limit_cfg;
                if (req.prio >= lvl_cap) begin
                    res.status = spq_pkg::STAT_BAD_PRIO;
                end else if (total >= pend_cap) begin
                    res.status = spq_pkg::STAT_FULL;
                end else begin
                    slots[req.prio][tail[req.prio]] = req;
                    tail[req.prio]  = (tail[req.prio] + 1) % DEPTH;
                    count[req.prio] = count[req.prio] + 1;
                    total = total + 1;
                end
            end else begin
                // scan every stored level from the top, whatever the level setting
                for (l = LEVELS - 1; l >= 0; l--) begin
                    if (!served && count[l] != 0) begin
                        res.job    = slots[l][head[l]];
                        res.handed = 1'b1;
                        head[l]    = (head[l] + 1) % DEPTH;
                        count[l]   = count[l] - 1;
                        if (total != 0) total = total - 1;
                        served = 1'b1;
                    end
                end
                if (!served) res.status = spq_pkg::STAT_EMPTY;
            end
            outcomes_due.push_back(res);
        endfunction

        function void check_result(logic [1:0] status, logic handed, job_t got);
            outcome_t want;
            if (outcomes_due.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
                return;
            end
            want = outcomes_due.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (handed !== want.handed) begin
                $error("dispatch_valid: expected %0d, got %0d", want.handed, handed);
                failures++;
            end
            if (got.id !== want.job.id) begin
                $error("out_id: expected %0h, got %0h", want.job.id, got.id);
                failures++;
            end
            if (got.prio !== want.job.prio) begin
                $error("out_prio: expected %0d, got %0d", want.job.prio, got.prio);
                failures++;
            end
            if (got.weight !== want.job.weight) begin
                $error("out_weight: expected %0h, got %0h", want.job.weight, got.weight);
                failures++;
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [spq_pkg::DATA_W-1:0]       s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [spq_pkg::DATA_W-1:0]       m_tdata;
    logic [2:0]                       m_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [spq_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [spq_pkg::CFG_DATA_W-1:0]   cfg_data;

    task_queue_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    bit          long_hold_due  = 1'b0;
    bit          long_hold_done = 1'b0;

    // Random phases: level setting, limit, share of pushes in percent, request count
    int phase_levels [PHASES] = '{7'h7F, 2, 8, 3, 1, 0, 12, 7'h78, 5, 8};
    int phase_limit  [PHASES] = '{127, 40, 64, 10, 1, 5, 100, 64, 0, 2};
    int phase_push   [PHASES] = '{85, 50, 30, 60, 60, 50, 70, 50, 50, 55};
    int phase_count  [PHASES] = '{150, 100, 100, 100, 60, 40, 120, 150, 60, 70};

    strict_priority_task_queue_core #(
        .PRIO_LEVELS(LEVELS),
        .CAPACITY   (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Give up on a hung block
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check every result taken from the block
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser[1:0], m_tuser[2], job_t'(m_tdata[spq_pkg::TASK_W-1:0]));
        end
    end

    // Receiver: alternate stall styles per window, with one long hold-off
    initial begin
        int window;
        int style;
        int tick;
        m_tready = 1'b0;
        tick = 0;
        forever begin
            style  = $urandom_range(0, 3);
            window = $urandom_range(16, 64);
            repeat (window) begin
                @(negedge aclk);
                tick++;
                if (long_hold_due && !long_hold_done) begin
                    m_tready <= 1'b0;
                    long_hold_done = 1'b1;
                    repeat (LONG_HOLD) @(negedge aclk);
                end
                case (style)
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    3:       m_tready <= (tick % 4 == 0);
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Offer one request; bursts of random length with random gaps between them
    task automatic send(logic mode, logic [spq_pkg::ID_W-1:0] id,
                        logic [spq_pkg::PRIO_W-1:0] prio,
                        logic [spq_pkg::WEIGHT_W-1:0] weight);
        int gap;
        job_t req;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        req = '{id: id, prio: prio, weight: weight};
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(spq_pkg::DATA_W - spq_pkg::TASK_W){1'b0}}, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, req);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [spq_pkg::CFG_IDX_W-1:0] idx,
                             logic [spq_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, data);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every result is back and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic configure(int levels, int limit);
        write_reg(spq_pkg::REG_NUM_PRIO, spq_pkg::CFG_DATA_W'(levels));
        write_reg(spq_pkg::REG_MAX_PEND, spq_pkg::CFG_DATA_W'(limit));
        cfg_valid <= 1'b0;
    endtask

    // Dispatch request with random, ignored task fields
    task automatic send_dispatch();
        send(spq_pkg::MODE_DISPATCH, $urandom, spq_pkg::PRIO_W'($urandom_range(0, 15)),
             spq_pkg::WEIGHT_W'($urandom_range(0, 255)));
    endtask

    task automatic send_random(int push_pct);
        logic mode;
        logic [spq_pkg::PRIO_W-1:0] prio;
        mode = ($urandom_range(0, 99) < push_pct) ? spq_pkg::MODE_PUSH
                                                  : spq_pkg::MODE_DISPATCH;
        prio = ($urandom_range(0, 3) == 0) ? spq_pkg::PRIO_W'($urandom_range(8, 15))
                                           : spq_pkg::PRIO_W'($urandom_range(0, 7));
        send(mode, $urandom, prio, spq_pkg::WEIGHT_W'($urandom_range(0, 255)));
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = spq_pkg::MODE_PUSH;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = spq_pkg::REG_NUM_PRIO;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE) @(negedge aclk);

        // Empty queue, field extremes, levels just above and far above the range
        send_dispatch();
        send(spq_pkg::MODE_PUSH, 32'h0000_0000, 4'd0, 8'h00);
        send(spq_pkg::MODE_PUSH, 32'hFFFF_FFFF, 4'd7, 8'hFF);
        send(spq_pkg::MODE_PUSH, 32'h1234_5678, 4'd8, 8'h11);
        send(spq_pkg::MODE_PUSH, 32'h8765_4321, 4'd15, 8'h22);
        send(spq_pkg::MODE_PUSH, 32'hA5A5_5A5A, 4'd3, 8'h5A);
        send(spq_pkg::MODE_PUSH, 32'h5A5A_A5A5, 4'd7, 8'hA5);
        repeat (5) send_dispatch();

        // No levels and no room: the priority check wins
        drain();
        configure(0, 0);
        send(spq_pkg::MODE_PUSH, 32'h0BAD_0001, 4'd0, 8'h01);
        send(spq_pkg::MODE_PUSH, 32'h0BAD_0002, 4'd15, 8'h02);

        // One level but a zero limit: full
        drain();
        configure(1, 0);
        send(spq_pkg::MODE_PUSH, 32'h0BAD_0003, 4'd0, 8'h03);

        // Settings above the storage act as the storage size
        drain();
        write_reg(REG_SPARE_2, spq_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(REG_SPARE_3, spq_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        configure(7'h7F, 7'h7F);
        send(spq_pkg::MODE_PUSH, 32'hC0DE_0007, 4'd7, 8'h77);
        send(spq_pkg::MODE_PUSH, 32'hC0DE_0008, 4'd8, 8'h88);
        send(spq_pkg::MODE_PUSH, 32'hC0DE_0002, 4'd2, 8'h22);

        // Shrink the levels with tasks still queued above the new range
        drain();
        configure(1, 64);
        send(spq_pkg::MODE_PUSH, 32'hC0DE_1007, 4'd7, 8'h17);
        repeat (3) send_dispatch();

        // Random phases; queued tasks carry over from one setting to the next
        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p % 3 == 1) write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                                      spq_pkg::CFG_DATA_W'($urandom_range(0, 127)));
            configure(phase_levels[p], phase_limit[p]);
            for (int n = 0; n < phase_count[p]; n++) begin
                if (p == 3 && n == 20) long_hold_due = 1'b1;
                send_random(phase_push[p]);
            end
        end

        drain();
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
